// ===== rtl/lwdt_pkg.sv =====
package lwdt_pkg;
    localparam int NUM_SETS_DEF    = 32;
    localparam int NUM_WAYS_DEF    = 8;
    localparam int OFFSET_BITS_DEF = 6;
    localparam int ADDR_BITS_DEF   = 32;
    localparam int STAMP_BITS_DEF  = 32;
    localparam int COUNT_BITS      = 32;
    localparam int WAY_OUT_BITS    = 3;

    typedef struct packed {
        logic load;
        logic rd;
        logic scan;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic rd_last;
        logic scan_last;
    } stat_t;
endpackage

// ===== rtl/lwdt_ram.sv =====
module lwdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/lwdt_ctrl.sv =====
module lwdt_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  lwdt_pkg::stat_t  stat,
    output lwdt_pkg::cmd_t   cmd
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       accept;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = accept;
                if (accept)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd = 1'b1;
                if (stat.rd_last)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_last)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

// ===== rtl/lwdt_dp.sv =====
module lwdt_dp #(
    parameter int NUM_SETS    = lwdt_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS    = lwdt_pkg::NUM_WAYS_DEF,
    parameter int OFFSET_BITS = lwdt_pkg::OFFSET_BITS_DEF,
    parameter int ADDR_BITS   = lwdt_pkg::ADDR_BITS_DEF,
    parameter int STAMP_BITS  = lwdt_pkg::STAMP_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lwdt_pkg::cmd_t                       cmd,
    output lwdt_pkg::stat_t                      stat,
    input  logic                                 action,
    input  logic [ADDR_BITS-1:0]                 address,
    output logic                                 hit,
    output logic [lwdt_pkg::WAY_OUT_BITS-1:0]    way,
    output logic                                 writeback,
    output logic [lwdt_pkg::COUNT_BITS-1:0]      miss_total,
    output logic [lwdt_pkg::COUNT_BITS-1:0]      writeback_total
);
    localparam int LINES     = NUM_SETS * NUM_WAYS;
    localparam int LIDX_BITS = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int SET_BITS  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_BITS  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int WCNT_BITS = $clog2(NUM_WAYS + 1);
    localparam int LINE_BITS = ADDR_BITS - OFFSET_BITS;
    localparam int TAG_BITS  = LINE_BITS;
    localparam int MEM_W     = TAG_BITS + STAMP_BITS;
    localparam logic [lwdt_pkg::COUNT_BITS-1:0] CNT_MAX = '1;

    logic [LINE_BITS-1:0]  line;
    logic                  store_reg;
    logic [SET_BITS-1:0]   set_reg;
    logic [TAG_BITS-1:0]   tag_reg;
    logic [WCNT_BITS-1:0]  rd_cnt_reg, sc_cnt_reg;
    logic [STAMP_BITS-1:0] stamp_reg;
    logic [LINES-1:0]      valid_reg, dirty_reg;
    logic                  hit_reg, have_inv_reg, found_reg;
    logic [WAY_BITS-1:0]   victim_reg;
    logic [STAMP_BITS-1:0] oldest_reg;
    logic                  wb_reg;
    logic [lwdt_pkg::COUNT_BITS-1:0] miss_reg, wbc_reg;

    logic [WAY_BITS-1:0]   sc_way;
    logic [LIDX_BITS-1:0]  sc_idx, rd_idx, fin_idx, w_idx;
    logic [MEM_W-1:0]      rdata, wdata;
    logic                  we;
    logic [TAG_BITS-1:0]   r_tag;
    logic [STAMP_BITS-1:0] r_stamp;
    logic                  r_valid;
    logic                  is_hit;
    logic [WAY_BITS-1:0]   fin_way;
    logic                  fin_hit;
    logic [STAMP_BITS-1:0] keep_stamp;
    logic [TAG_BITS-1:0]   keep_tag;

    assign line = address[ADDR_BITS-1:OFFSET_BITS];

    function automatic logic [LIDX_BITS-1:0] lidx(input logic [SET_BITS-1:0] s,
                                                 input logic [WAY_BITS-1:0] w);
        logic [LIDX_BITS+WAY_BITS-1:0] v;
        begin
            v = LIDX_BITS'(s) * LIDX_BITS'(NUM_WAYS) + LIDX_BITS'(w);
            lidx = v[LIDX_BITS-1:0];
        end
    endfunction

    assign rd_idx  = lidx(set_reg, rd_cnt_reg[WAY_BITS-1:0]);
    assign sc_way  = sc_cnt_reg[WAY_BITS-1:0];
    assign sc_idx  = lidx(set_reg, sc_way);
    assign r_tag   = rdata[MEM_W-1:STAMP_BITS];
    assign r_stamp = rdata[STAMP_BITS-1:0];
    assign r_valid = valid_reg[sc_idx];
    assign is_hit  = r_valid && (r_tag == tag_reg);

    assign stat.rd_last   = 1'b1;
    assign stat.scan_last = (sc_cnt_reg == WCNT_BITS'(NUM_WAYS - 1)) || (!hit_reg && is_hit);

    // result of this final scan step
    always_comb
    begin
        fin_hit = hit_reg || is_hit;
        if (hit_reg || is_hit)
        begin
            fin_way = is_hit && !hit_reg ? sc_way : victim_reg;
        end
        else if (!r_valid && !have_inv_reg)
        begin
            fin_way = sc_way;
        end
        else if (r_valid && !have_inv_reg && (!found_reg || r_stamp < oldest_reg))
        begin
            fin_way = sc_way;
        end
        else
        begin
            fin_way = victim_reg;
        end
    end

    assign fin_idx    = lidx(set_reg, fin_way);
    assign keep_tag   = tag_reg;
    assign keep_stamp = stamp_reg;
    assign we         = cmd.commit;
    assign w_idx      = fin_idx;
    assign wdata      = {keep_tag, keep_stamp};

    lwdt_ram #(.WIDTH(MEM_W), .DEPTH(LINES)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (w_idx),
        .wdata (wdata),
        .raddr (cmd.scan ? lidx(set_reg, sc_way + WAY_BITS'(1)) : rd_idx),
        .rdata (rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            store_reg <= action;
            set_reg   <= SET_BITS'(line % NUM_SETS);
            tag_reg   <= TAG_BITS'(line / NUM_SETS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_cnt_reg   <= '0;
            sc_cnt_reg   <= '0;
            stamp_reg    <= '0;
            valid_reg    <= '0;
            dirty_reg    <= '0;
            hit_reg      <= 1'b0;
            have_inv_reg <= 1'b0;
            found_reg    <= 1'b0;
            victim_reg   <= '0;
            oldest_reg   <= '0;
            wb_reg       <= 1'b0;
            miss_reg     <= '0;
            wbc_reg      <= '0;
            hit          <= 1'b0;
            way          <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                rd_cnt_reg   <= '0;
                sc_cnt_reg   <= '0;
                hit_reg      <= 1'b0;
                have_inv_reg <= 1'b0;
                found_reg    <= 1'b0;
                victim_reg   <= '0;
                stamp_reg    <= stamp_reg + STAMP_BITS'(1);
            end
            if (cmd.scan)
            begin
                sc_cnt_reg <= sc_cnt_reg + WCNT_BITS'(1);
                if (!hit_reg && is_hit)
                begin
                    hit_reg    <= 1'b1;
                    victim_reg <= sc_way;
                end
                else if (!hit_reg && !r_valid && !have_inv_reg)
                begin
                    have_inv_reg <= 1'b1;
                    victim_reg   <= sc_way;
                end
                else if (!hit_reg && r_valid && !have_inv_reg
                         && (!found_reg || r_stamp < oldest_reg))
                begin
                    found_reg  <= 1'b1;
                    oldest_reg <= r_stamp;
                    victim_reg <= sc_way;
                end
            end
            if (cmd.commit)
            begin
                hit <= fin_hit;
                way <= lwdt_pkg::WAY_OUT_BITS'(fin_way);
                if (fin_hit)
                begin
                    wb_reg <= 1'b0;
                    if (store_reg)
                    begin
                        dirty_reg[fin_idx] <= 1'b1;
                    end
                end
                else
                begin
                    wb_reg             <= valid_reg[fin_idx] && dirty_reg[fin_idx];
                    valid_reg[fin_idx] <= 1'b1;
                    dirty_reg[fin_idx] <= store_reg;
                    if (miss_reg != CNT_MAX)
                    begin
                        miss_reg <= miss_reg + 1'b1;
                    end
                    if (valid_reg[fin_idx] && dirty_reg[fin_idx] && wbc_reg != CNT_MAX)
                    begin
                        wbc_reg <= wbc_reg + 1'b1;
                    end
                end
            end
        end
    end

    assign writeback       = wb_reg;
    assign miss_total      = miss_reg;
    assign writeback_total = wbc_reg;
endmodule

// ===== rtl/lru_writeback_dcache_tags.sv =====
// Tag side of a set-associative write-back, write-allocate data cache with
// LRU replacement by access stamps. One access is in flight at a time: it
// is captured, way 0 of the tag/stamp memory is read, then the ways are
// examined in turn (the single read port of that memory scans the set),
// stopping early on a hit; the result then waits in the output register
// until taken, and the block returns to idle before the next transfer is
// accepted.
module lru_writeback_dcache_tags #(
    parameter int NUM_SETS    = lwdt_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS    = lwdt_pkg::NUM_WAYS_DEF,
    parameter int OFFSET_BITS = lwdt_pkg::OFFSET_BITS_DEF,
    parameter int ADDR_BITS   = lwdt_pkg::ADDR_BITS_DEF,
    parameter int STAMP_BITS  = lwdt_pkg::STAMP_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              action,
    input  logic [ADDR_BITS-1:0]              address,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              hit,
    output logic [lwdt_pkg::WAY_OUT_BITS-1:0] way,
    output logic                              writeback,
    output logic [lwdt_pkg::COUNT_BITS-1:0]   miss_total,
    output logic [lwdt_pkg::COUNT_BITS-1:0]   writeback_total
);
    lwdt_pkg::cmd_t  cmd;
    lwdt_pkg::stat_t stat;

    lwdt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    lwdt_dp #(
        .NUM_SETS    (NUM_SETS),
        .NUM_WAYS    (NUM_WAYS),
        .OFFSET_BITS (OFFSET_BITS),
        .ADDR_BITS   (ADDR_BITS),
        .STAMP_BITS  (STAMP_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .action          (action),
        .address         (address),
        .hit             (hit),
        .way             (way),
        .writeback       (writeback),
        .miss_total      (miss_total),
        .writeback_total (writeback_total)
    );
endmodule

// ===== dv/lru_writeback_dcache_tags_tb.sv =====
module lru_writeback_dcache_tags_tb;
    localparam int SETS     = lwdt_pkg::NUM_SETS_DEF;
    localparam int WAYS     = lwdt_pkg::NUM_WAYS_DEF;
    localparam int OFFS     = lwdt_pkg::OFFSET_BITS_DEF;
    localparam int IDLE_MAX = 200000;

    typedef enum logic {ACC_LOAD = 1'b0, ACC_STORE = 1'b1} acc_e;

    typedef struct packed {
        logic                              hit;
        logic [lwdt_pkg::WAY_OUT_BITS-1:0] way;
        logic                              writeback;
        logic [lwdt_pkg::COUNT_BITS-1:0]   miss_total;
        logic [lwdt_pkg::COUNT_BITS-1:0]   writeback_total;
    } lookup_t;

    class tag_scoreboard;
        bit                              line_valid [SETS*WAYS];
        bit                              line_dirty [SETS*WAYS];
        logic [25:0]                     line_tag   [SETS*WAYS];
        logic [31:0]                     line_age   [SETS*WAYS];
        logic [31:0]                     stamp;
        logic [lwdt_pkg::COUNT_BITS-1:0] misses;
        logic [lwdt_pkg::COUNT_BITS-1:0] wbs;
        lookup_t                         pending [$];
        int                              errors;

        function new();
            foreach (line_valid[i])
            begin
                line_valid[i] = 0;
                line_dirty[i] = 0;
                line_tag[i]   = '0;
                line_age[i]   = '0;
            end
            stamp  = '0;
            misses = '0;
            wbs    = '0;
            errors = 0;
        endfunction

        function void note_access(logic st, logic [31:0] addr);
            logic [25:0] ln;
            logic [25:0] tg;
            int          base;
            int          victim;
            bit          found;
            bit          inv;
            logic [31:0] oldest;
            lookup_t     r;
            ln     = 26'(addr >> OFFS);
            base   = (ln % SETS) * WAYS;
            tg     = 26'(ln / SETS);
            found  = 0;
            inv    = 0;
            victim = 0;
            oldest = '0;
            r      = '0;
            stamp  = stamp + 32'd1;
            for (int w = 0; w < WAYS; w++)
            begin
                if (!found && line_valid[base+w] && line_tag[base+w] == tg)
                begin
                    found  = 1;
                    victim = w;
                end
            end
            if (found)
            begin
                line_age[base+victim] = stamp;
                if (st)
                    line_dirty[base+victim] = 1;
            end
            else
            begin
                for (int w = 0; w < WAYS; w++)
                begin
                    if (!line_valid[base+w])
                    begin
                        if (!inv)
                        begin
                            inv    = 1;
                            victim = w;
                        end
                    end
                    else if (!inv && (w == 0 || line_age[base+w] < oldest))
                    begin
                        oldest = line_age[base+w];
                        victim = w;
                    end
                end
                r.writeback = line_valid[base+victim] && line_dirty[base+victim];
                line_valid[base+victim] = 1;
                line_tag[base+victim]   = tg;
                line_age[base+victim]   = stamp;
                line_dirty[base+victim] = st;
                if (misses != '1)
                    misses = misses + 1'b1;
                if (r.writeback && wbs != '1)
                    wbs = wbs + 1'b1;
            end
            r.hit             = found;
            r.way             = victim[lwdt_pkg::WAY_OUT_BITS-1:0];
            r.miss_total      = misses;
            r.writeback_total = wbs;
            pending.push_back(r);
        endfunction

        function void check_lookup(lookup_t got);
            lookup_t exp;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected transfer: %p", got);
                return;
            end
            exp = pending.pop_front();
            if (got !== exp)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected %p actual %p", exp, got);
            end
        endfunction
    endclass

    logic                              clk;
    logic                              rst_n;
    logic                              in_valid;
    logic                              in_stall;
    logic                              action;
    logic [31:0]                       address;
    logic                              out_valid;
    logic                              out_stall;
    logic                              hit;
    logic [lwdt_pkg::WAY_OUT_BITS-1:0] way;
    logic                              writeback;
    logic [lwdt_pkg::COUNT_BITS-1:0]   miss_total;
    logic [lwdt_pkg::COUNT_BITS-1:0]   writeback_total;

    tag_scoreboard sb;
    int            src_idle;
    int            snk_idle;
    bit            hold_sink;
    int            quiet;

    lru_writeback_dcache_tags dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .address(address), .out_valid(out_valid),
        .out_stall(out_stall), .hit(hit), .way(way), .writeback(writeback),
        .miss_total(miss_total), .writeback_total(writeback_total)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        sb        = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        action    = 1'b0;
        address   = '0;
        out_stall = 1'b0;
        src_idle  = 0;
        snk_idle  = 0;
        hold_sink = 0;
        quiet     = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_sink)
                out_stall <= 1'b1;
            else
                out_stall <= ($urandom_range(99) < snk_idle);
            if (out_valid && !out_stall)
                sb.check_lookup({hit, way, writeback, miss_total, writeback_total});
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > IDLE_MAX)
        begin
            $display("[lru_writeback_dcache_tags] ERROR");
            $finish;
        end
    end

    task automatic send(input logic st, input logic [31:0] addr);
        while ($urandom_range(99) < src_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= st;
        address  <= addr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_access(st, addr);
    endtask

    task automatic idle_in();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        idle_in();
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    // well-formed: addresses cluster in a few sets and tags to exercise reuse and eviction
    function automatic logic [31:0] pick_addr();
        logic [31:0] a;
        a = $urandom;
        if ($urandom_range(9) < 8)
        begin
            a[31:OFFS+5] = (31-OFFS-4)'($urandom_range(11));
            a[OFFS+4:OFFS] = 5'($urandom_range(3));
            if ($urandom_range(3) == 0)
                a[31] = 1'b1;
        end
        return a;
    endfunction

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++)
            send(1'($urandom_range(1)), pick_addr());
    endtask

    initial
    begin
        #1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(ACC_LOAD, 32'h0000_0000);
        send(ACC_LOAD, 32'h0000_003F);
        send(ACC_STORE, 32'hFFFF_FFFF);
        send(ACC_LOAD, 32'hFFFF_FFC0);
        // fill one set, then evict dirty and clean victims
        for (int t = 0; t < 10; t++)
            send(t[0] ? ACC_STORE : ACC_LOAD, {t[20:0], 5'd3, 6'd0});
        send(ACC_STORE, {21'd2, 5'd3, 6'd0});
        send(ACC_LOAD, {21'd11, 5'd3, 6'd0});
        send(ACC_LOAD, {21'd12, 5'd3, 6'd0});
        send(ACC_STORE, 32'h5555_5555);
        send(ACC_LOAD, 32'hAAAA_AAAA);
        drain();

        src_idle = 12;
        snk_idle = 81;
        run_random(400);
        drain();

        hold_sink = 1;
        fork
            begin
                repeat (300) @(posedge clk);
                hold_sink = 0;
            end
            run_random(20);
        join
        drain();

        src_idle = 81;
        snk_idle = 12;
        run_random(500);
        drain();

        src_idle = 0;
        snk_idle = 0;
        run_random(680);
        drain();

        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[lru_writeback_dcache_tags] OK");
        else
            $display("[lru_writeback_dcache_tags] ERROR");
        $finish;
    end
endmodule
